[hdl/vcb_pkg.sv]
// shared types, constants and fixed-point helpers for the verlet circle body
// no dependencies
`timescale 1ns / 1ps

package vcb_pkg;

    localparam int WORD_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int CMD_W      = 3;
    localparam int RAD_W      = 27;
    localparam int DT_W       = 17;
    localparam int ARENA_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 27;
    localparam int SAT_W      = 36;

    localparam int MUL_A_W    = 40;
    localparam int MUL_B_W    = 32;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W  = $clog2(MUL_B_W);

    localparam int DIV_N_W    = 48;
    localparam int DIV_D_W    = 32;
    localparam int DIV_Q_W    = FRAC_W + 1;
    localparam int DIV_CNT_W  = $clog2(DIV_Q_W);

    localparam int SQRT_N_W   = 64;
    localparam int SQRT_R_W   = 32;
    localparam int SQRT_CNT_W = $clog2(SQRT_R_W);

    typedef logic signed [WORD_W-1:0] word_t;

    localparam word_t WORD_MAX  = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t WORD_MIN  = {1'b1, {(WORD_W-1){1'b0}}};
    localparam word_t START_POS = word_t'(20 * (1 << FRAC_W));

    localparam logic [RAD_W-1:0]   RADIUS_RESET = RAD_W'(10 * (1 << FRAC_W));
    localparam logic [DT_W-1:0]    DT_RESET     = DT_W'(1092);
    localparam logic [ARENA_W-1:0] WIDTH_RESET  = ARENA_W'(800);
    localparam logic [ARENA_W-1:0] HEIGHT_RESET = ARENA_W'(600);

    localparam logic [MUL_CNT_W-1:0]  MUL_LAST  = MUL_CNT_W'(MUL_B_W - 1);
    localparam logic [DIV_CNT_W-1:0]  DIV_LAST  = DIV_CNT_W'(DIV_Q_W - 1);
    localparam logic [SQRT_CNT_W-1:0] SQRT_LAST = SQRT_CNT_W'(SQRT_R_W - 1);
    localparam logic [SQRT_N_W-1:0]   SQRT_TOP_BIT = {2'b01, {(SQRT_N_W-2){1'b0}}};

    localparam logic [WORD_W:0] NEG_LIMIT = {2'b01, {(WORD_W-1){1'b0}}};

    typedef enum logic [CMD_W-1:0] {
        CMD_STEP    = 3'd0,
        CMD_ACCEL   = 3'd1,
        CMD_WALL    = 3'd2,
        CMD_COLLIDE = 3'd3,
        CMD_SET_VEL = 3'd4,
        CMD_ADD_VEL = 3'd5
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS = 2'd0,
        CFG_DT     = 2'd1,
        CFG_WIDTH  = 2'd2,
        CFG_HEIGHT = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        word_t            vec_x;
        word_t            vec_y;
        logic [RAD_W-1:0] target_radius;
    } in_word_t;

    typedef struct packed {
        word_t pos_x;
        word_t pos_y;
        word_t target_x;
        word_t target_y;
        logic  status;
    } out_word_t;

    typedef struct packed {
        logic                      start;
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic              neg;
        logic [PROD_W-1:0] prod;
    } mul_rsp_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] num;
        logic [DIV_D_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_Q_W-1:0] quo;
    } div_rsp_t;

    typedef struct packed {
        logic                start;
        logic [SQRT_N_W-1:0] rad;
    } sqrt_req_t;

    typedef struct packed {
        logic                done;
        logic [SQRT_R_W-1:0] root;
    } sqrt_rsp_t;

    function automatic logic signed [SAT_W-1:0] sx(input word_t v);
        return SAT_W'(v);
    endfunction

    function automatic word_t sat_word(input logic signed [SAT_W-1:0] v);
        logic [SAT_W-WORD_W:0] top;
        word_t                 res;
        top = v[SAT_W-1:WORD_W-1];
        if (top == '0 || top == '1) begin
            res = word_t'(v[WORD_W-1:0]);
        end else begin
            res = v[SAT_W-1] ? WORD_MIN : WORD_MAX;
        end
        return res;
    endfunction

    // product magnitude and sign to a floored, saturated fixed-point word
    function automatic word_t mulq_fix(input logic [PROD_W-1:0] p, input logic neg);
        logic [PROD_W-FRAC_W-1:0] q;
        logic [PROD_W-FRAC_W-1:0] qc;
        word_t                    res;
        q  = p[PROD_W-1:FRAC_W];
        qc = q + (PROD_W-FRAC_W)'(|p[FRAC_W-1:0]);
        if (!neg) begin
            if (q > (PROD_W-FRAC_W)'(WORD_MAX)) begin
                res = WORD_MAX;
            end else begin
                res = word_t'(q[WORD_W-1:0]);
            end
        end else begin
            if (qc > (PROD_W-FRAC_W)'(NEG_LIMIT)) begin
                res = WORD_MIN;
            end else begin
                res = word_t'(WORD_W'(0) - qc[WORD_W-1:0]);
            end
        end
        return res;
    endfunction

endpackage

[hdl/vcb_mul.sv]
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on vcb_pkg
`timescale 1ns / 1ps

module vcb_mul import vcb_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic                 neg_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic [PROD_W-1:0]    am_reg;
    logic [PROD_W-1:0]    acc_reg;
    logic [MUL_B_W-1:0]   bm_reg;
    logic [MUL_A_W-1:0]   a_mag;
    logic [MUL_B_W-1:0]   b_mag;

    always_comb begin
        a_mag = req.a[MUL_A_W-1] ? unsigned'(-req.a) : unsigned'(req.a);
        b_mag = req.b[MUL_B_W-1] ? unsigned'(-req.b) : unsigned'(req.b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                acc_reg  <= '0;
                neg_reg  <= req.a[MUL_A_W-1] ^ req.b[MUL_B_W-1];
                am_reg   <= {{(PROD_W-MUL_A_W){1'b0}}, a_mag};
                bm_reg   <= b_mag;
            end else if (busy_reg) begin
                acc_reg <= acc_reg + (bm_reg[0] ? am_reg : '0);
                am_reg  <= am_reg << 1;
                bm_reg  <= bm_reg >> 1;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp = '{done: done_reg, neg: neg_reg, prod: acc_reg};

endmodule

[hdl/vcb_div.sv]
// restoring divider, one quotient bit per cycle, quotient known below 2^17
// depends on vcb_pkg
`timescale 1ns / 1ps

module vcb_div import vcb_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_D_W-1:0]   den_reg;
    logic [DIV_Q_W-1:0]   nbits_reg;
    logic [DIV_Q_W-1:0]   quo_reg;
    logic [DIV_D_W:0]     trial;
    logic                 fits;

    always_comb begin
        trial = {rem_reg, nbits_reg[DIV_Q_W-1]};
        fits  = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg  <= 1'b1;
                cnt_reg   <= '0;
                // high part is already below the divisor
                rem_reg   <= DIV_D_W'(req.num[DIV_N_W-1:DIV_Q_W]);
                nbits_reg <= req.num[DIV_Q_W-1:0];
                den_reg   <= req.den;
                quo_reg   <= '0;
            end else if (busy_reg) begin
                rem_reg   <= fits ? DIV_D_W'(trial - {1'b0, den_reg}) : trial[DIV_D_W-1:0];
                quo_reg   <= {quo_reg[DIV_Q_W-2:0], fits};
                nbits_reg <= nbits_reg << 1;
                cnt_reg   <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp = '{done: done_reg, quo: quo_reg};

endmodule

[hdl/vcb_sqrt.sv]
// digit-by-digit integer square root, one root bit per cycle
// depends on vcb_pkg
`timescale 1ns / 1ps

module vcb_sqrt import vcb_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  sqrt_req_t req,
    output sqrt_rsp_t rsp
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [SQRT_CNT_W-1:0] cnt_reg;
    logic [SQRT_N_W-1:0]   n_reg;
    logic [SQRT_N_W-1:0]   r_reg;
    logic [SQRT_N_W-1:0]   bit_reg;
    logic [SQRT_N_W-1:0]   sum;

    assign sum = r_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                n_reg    <= req.rad;
                r_reg    <= '0;
                bit_reg  <= SQRT_TOP_BIT;
            end else if (busy_reg) begin
                if (n_reg >= sum) begin
                    n_reg <= n_reg - sum;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end else begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == SQRT_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp = '{done: done_reg, root: r_reg[SQRT_R_W-1:0]};

endmodule

[hdl/verlet_circle_body_step.sv]
// one command at a time; accelerate, wall collide and unknown commands go from the
// dispatch state straight to the output state, while step (4 multiplies), velocity
// (2 multiplies) and collide (up to 8 multiplies, 4 divides, one root) run on the
// serial vcb_mul, vcb_div and vcb_sqrt units; the next word is taken the cycle after
// the result is loaded. synchronous reset puts the body at (20,20) with zero
// acceleration and the registers at their defaults; no clearing pass
`timescale 1ns / 1ps

module verlet_circle_body_step import vcb_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_DISPATCH, ST_STEP_X1, ST_STEP_X2, ST_STEP_Y1, ST_STEP_Y2,
        ST_VEL_X, ST_VEL_Y, ST_SQ_X, ST_SQ_Y, ST_ROOT, ST_DIV_NX, ST_DIV_NY,
        ST_DIV_M1, ST_DIV_M2, ST_MV1, ST_MV2, ST_PX, ST_PY, ST_TX, ST_TY, ST_OUT
    } state_t;

    state_t              state_reg;
    in_word_t            in_reg;
    word_t               pos_x_reg, pos_y_reg, prev_x_reg, prev_y_reg;
    word_t               acc_x_reg, acc_y_reg;
    logic [RAD_W-1:0]    radius_reg;
    logic [DT_W-1:0]     dt_reg;
    logic [ARENA_W-1:0]  width_reg, height_reg;
    word_t               mv1_reg, mv2_reg, tx_reg, ty_reg;
    logic                status_reg;
    logic [WORD_W-2:0]   ux_reg, uy_reg;
    logic                shift_reg, dx_neg_reg, dy_neg_reg;
    logic [SQRT_N_W-1:0] sq_reg;
    logic [SQRT_R_W-1:0] lenp_reg;
    logic [DIV_Q_W-1:0]  nxq_reg, nyq_reg, m1_reg, m2_reg;
    out_word_t           out_reg;
    logic                out_valid_reg;
    mul_req_t            mul_req_reg;
    div_req_t            div_req_reg;
    sqrt_req_t           sqrt_req_reg;
    mul_rsp_t            mul_rsp;
    div_rsp_t            div_rsp;
    sqrt_rsp_t           sqrt_rsp;

    word_t                   fix_w;
    logic signed [WORD_W:0]  dx, dy;
    logic [WORD_W-1:0]       ux_full, uy_full;
    logic                    shift_c;
    logic [WORD_W-2:0]       ux_sh, uy_sh;
    logic [RAD_W:0]          rsum;
    logic [WORD_W:0]         len;
    logic signed [WORD_W+1:0] d_c;
    word_t                   nx_s, ny_s, nx_mag, ny_mag;
    word_t                   clamp_x, clamp_y;
    logic [MUL_B_W-1:0]      dt_b;

    function automatic word_t clamp_axis(input word_t p, input logic [ARENA_W-1:0] ext,
                                         input logic [RAD_W-1:0] rad);
        word_t r;
        word_t hi;
        word_t res;
        r   = word_t'({{(WORD_W-RAD_W){1'b0}}, rad});
        hi  = ext[ARENA_W-1] ? WORD_MAX : word_t'({ext, {FRAC_W{1'b0}}});
        hi  = hi - r;
        res = p;
        // upper bound first, lower bound wins on a narrow arena
        if (res > hi) res = hi;
        if (res < r) res = r;
        return res;
    endfunction

    vcb_mul u_mul (.aclk(aclk), .aresetn(aresetn), .req(mul_req_reg), .rsp(mul_rsp));
    vcb_div u_div (.aclk(aclk), .aresetn(aresetn), .req(div_req_reg), .rsp(div_rsp));
    vcb_sqrt u_sqrt (.aclk(aclk), .aresetn(aresetn), .req(sqrt_req_reg), .rsp(sqrt_rsp));

    always_comb begin
        fix_w   = mulq_fix(mul_rsp.prod, mul_rsp.neg);
        dx      = {pos_x_reg[WORD_W-1], pos_x_reg} - {in_reg.vec_x[WORD_W-1], in_reg.vec_x};
        dy      = {pos_y_reg[WORD_W-1], pos_y_reg} - {in_reg.vec_y[WORD_W-1], in_reg.vec_y};
        ux_full = dx[WORD_W] ? WORD_W'(-dx) : WORD_W'(dx);
        uy_full = dy[WORD_W] ? WORD_W'(-dy) : WORD_W'(dy);
        // halve both when either magnitude reaches 2^31
        shift_c = ux_full[WORD_W-1] | uy_full[WORD_W-1];
        ux_sh   = shift_c ? ux_full[WORD_W-1:1] : ux_full[WORD_W-2:0];
        uy_sh   = shift_c ? uy_full[WORD_W-1:1] : uy_full[WORD_W-2:0];
        rsum    = {1'b0, radius_reg} + {1'b0, in_reg.target_radius};
        len     = shift_reg ? {lenp_reg, 1'b0} : {1'b0, lenp_reg};
        d_c     = $signed({1'b0, len}) - $signed({{(WORD_W+1-RAD_W){1'b0}}, rsum});
        nx_mag  = word_t'({{(WORD_W-DIV_Q_W){1'b0}}, nxq_reg});
        ny_mag  = word_t'({{(WORD_W-DIV_Q_W){1'b0}}, nyq_reg});
        nx_s    = dx_neg_reg ? -nx_mag : nx_mag;
        ny_s    = dy_neg_reg ? -ny_mag : ny_mag;
        clamp_x = clamp_axis(pos_x_reg, width_reg, radius_reg);
        clamp_y = clamp_axis(pos_y_reg, height_reg, radius_reg);
        dt_b    = {{(MUL_B_W-DT_W){1'b0}}, dt_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            pos_x_reg          <= START_POS;
            pos_y_reg          <= START_POS;
            prev_x_reg         <= START_POS;
            prev_y_reg         <= START_POS;
            acc_x_reg          <= '0;
            acc_y_reg          <= '0;
            radius_reg         <= RADIUS_RESET;
            dt_reg             <= DT_RESET;
            width_reg          <= WIDTH_RESET;
            height_reg         <= HEIGHT_RESET;
            out_valid_reg      <= 1'b0;
            mul_req_reg.start  <= 1'b0;
            div_req_reg.start  <= 1'b0;
            sqrt_req_reg.start <= 1'b0;
        end else begin
            mul_req_reg.start  <= 1'b0;
            div_req_reg.start  <= 1'b0;
            sqrt_req_reg.start <= 1'b0;

            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_RADIUS: radius_reg <= cfg_wr_data[RAD_W-1:0];
                    CFG_DT:     dt_reg     <= cfg_wr_data[DT_W-1:0];
                    CFG_WIDTH:  width_reg  <= cfg_wr_data[ARENA_W-1:0];
                    CFG_HEIGHT: height_reg <= cfg_wr_data[ARENA_W-1:0];
                    default: ;
                endcase
            end

            if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        in_reg    <= s_data;
                        state_reg <= ST_DISPATCH;
                    end
                end
                ST_DISPATCH: begin
                    tx_reg     <= '0;
                    ty_reg     <= '0;
                    status_reg <= 1'b0;
                    case (in_reg.command)
                        CMD_STEP: begin
                            mul_req_reg <= '{start: 1'b1, a: MUL_A_W'(acc_x_reg), b: dt_b};
                            state_reg   <= ST_STEP_X1;
                        end
                        CMD_ACCEL: begin
                            acc_x_reg <= sat_word(sx(acc_x_reg) + sx(in_reg.vec_x));
                            acc_y_reg <= sat_word(sx(acc_y_reg) + sx(in_reg.vec_y));
                            state_reg <= ST_OUT;
                        end
                        CMD_WALL: begin
                            pos_x_reg <= clamp_x;
                            pos_y_reg <= clamp_y;
                            state_reg <= ST_OUT;
                        end
                        CMD_COLLIDE: begin
                            tx_reg <= in_reg.vec_x;
                            ty_reg <= in_reg.vec_y;
                            if (dx == '0 && dy == '0) begin
                                status_reg <= 1'b1;
                                state_reg  <= ST_OUT;
                            end else begin
                                ux_reg      <= ux_sh;
                                uy_reg      <= uy_sh;
                                shift_reg   <= shift_c;
                                dx_neg_reg  <= dx[WORD_W];
                                dy_neg_reg  <= dy[WORD_W];
                                mul_req_reg <= '{start: 1'b1, a: MUL_A_W'(ux_sh),
                                                 b: MUL_B_W'(ux_sh)};
                                state_reg   <= ST_SQ_X;
                            end
                        end
                        CMD_SET_VEL, CMD_ADD_VEL: begin
                            mul_req_reg <= '{start: 1'b1, a: MUL_A_W'(in_reg.vec_x), b: dt_b};
                            state_reg   <= ST_VEL_X;
                        end
                        default: state_reg <= ST_OUT;
                    endcase
                end
                ST_STEP_X1: begin
                    if (mul_rsp.done) begin
                        mul_req_reg <= '{start: 1'b1, a: MUL_A_W'(fix_w), b: dt_b};
                        state_reg   <= ST_STEP_X2;
                    end
                end
                ST_STEP_X2: begin
                    if (mul_rsp.done) begin
                        pos_x_reg   <= sat_word(sx(pos_x_reg) + sx(pos_x_reg) - sx(prev_x_reg)
                                                + sx(fix_w));
                        prev_x_reg  <= pos_x_reg;
                        acc_x_reg   <= '0;
                        mul_req_reg <= '{start: 1'b1, a: MUL_A_W'(acc_y_reg), b: dt_b};
                        state_reg   <= ST_STEP_Y1;
                    end
                end
                ST_STEP_Y1: begin
                    if (mul_rsp.done) begin
                        mul_req_reg <= '{start: 1'b1, a: MUL_A_W'(fix_w), b: dt_b};
                        state_reg   <= ST_STEP_Y2;
                    end
                end
                ST_STEP_Y2: begin
                    if (mul_rsp.done) begin
                        pos_y_reg  <= sat_word(sx(pos_y_reg) + sx(pos_y_reg) - sx(prev_y_reg)
                                               + sx(fix_w));
                        prev_y_reg <= pos_y_reg;
                        acc_y_reg  <= '0;
                        state_reg  <= ST_OUT;
                    end
                end
                ST_VEL_X: begin
                    if (mul_rsp.done) begin
                        prev_x_reg  <= sat_word(((in_reg.command == CMD_SET_VEL) ?
                                                 sx(pos_x_reg) : sx(prev_x_reg)) - sx(fix_w));
                        mul_req_reg <= '{start: 1'b1, a: MUL_A_W'(in_reg.vec_y), b: dt_b};
                        state_reg   <= ST_VEL_Y;
                    end
                end
                ST_VEL_Y: begin
                    if (mul_rsp.done) begin
                        prev_y_reg <= sat_word(((in_reg.command == CMD_SET_VEL) ?
                                                sx(pos_y_reg) : sx(prev_y_reg)) - sx(fix_w));
                        state_reg  <= ST_OUT;
                    end
                end
                ST_SQ_X: begin
                    if (mul_rsp.done) begin
                        sq_reg      <= mul_rsp.prod[SQRT_N_W-1:0];
                        mul_req_reg <= '{start: 1'b1, a: MUL_A_W'(uy_reg), b: MUL_B_W'(uy_reg)};
                        state_reg   <= ST_SQ_Y;
                    end
                end
                ST_SQ_Y: begin
                    if (mul_rsp.done) begin
                        sqrt_req_reg <= '{start: 1'b1, rad: sq_reg + mul_rsp.prod[SQRT_N_W-1:0]};
                        state_reg    <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    if (sqrt_rsp.done) begin
                        lenp_reg    <= sqrt_rsp.root;
                        div_req_reg <= '{start: 1'b1,
                                         num: {{(DIV_N_W-WORD_W+1-FRAC_W){1'b0}}, ux_reg,
                                               {FRAC_W{1'b0}}},
                                         den: sqrt_rsp.root};
                        state_reg   <= ST_DIV_NX;
                    end
                end
                ST_DIV_NX: begin
                    if (div_rsp.done) begin
                        nxq_reg     <= div_rsp.quo;
                        div_req_reg <= '{start: 1'b1,
                                         num: {{(DIV_N_W-WORD_W+1-FRAC_W){1'b0}}, uy_reg,
                                               {FRAC_W{1'b0}}},
                                         den: lenp_reg};
                        state_reg   <= ST_DIV_NY;
                    end
                end
                ST_DIV_NY: begin
                    if (div_rsp.done) begin
                        nyq_reg <= div_rsp.quo;
                        if (rsum != '0) begin
                            div_req_reg <= '{start: 1'b1,
                                             num: {{(DIV_N_W-RAD_W-FRAC_W){1'b0}}, radius_reg,
                                                   {FRAC_W{1'b0}}},
                                             den: {{(DIV_D_W-RAD_W-1){1'b0}}, rsum}};
                            state_reg   <= ST_DIV_M1;
                        end else begin
                            // zero radius sum: no push either way
                            m2_reg      <= '0;
                            mul_req_reg <= '{start: 1'b1, a: MUL_A_W'(d_c), b: '0};
                            state_reg   <= ST_MV1;
                        end
                    end
                end
                ST_DIV_M1: begin
                    if (div_rsp.done) begin
                        m1_reg      <= div_rsp.quo;
                        div_req_reg <= '{start: 1'b1,
                                         num: {{(DIV_N_W-RAD_W-FRAC_W){1'b0}},
                                               in_reg.target_radius, {FRAC_W{1'b0}}},
                                         den: {{(DIV_D_W-RAD_W-1){1'b0}}, rsum}};
                        state_reg   <= ST_DIV_M2;
                    end
                end
                ST_DIV_M2: begin
                    if (div_rsp.done) begin
                        m2_reg      <= div_rsp.quo;
                        mul_req_reg <= '{start: 1'b1, a: MUL_A_W'(d_c),
                                         b: {{(MUL_B_W-DIV_Q_W){1'b0}}, m1_reg}};
                        state_reg   <= ST_MV1;
                    end
                end
                ST_MV1: begin
                    if (mul_rsp.done) begin
                        mv1_reg     <= fix_w;
                        mul_req_reg <= '{start: 1'b1, a: MUL_A_W'(d_c),
                                         b: {{(MUL_B_W-DIV_Q_W){1'b0}}, m2_reg}};
                        state_reg   <= ST_MV2;
                    end
                end
                ST_MV2: begin
                    if (mul_rsp.done) begin
                        mv2_reg     <= fix_w;
                        mul_req_reg <= '{start: 1'b1, a: MUL_A_W'(mv1_reg), b: nx_s};
                        state_reg   <= ST_PX;
                    end
                end
                ST_PX: begin
                    if (mul_rsp.done) begin
                        pos_x_reg   <= sat_word(sx(pos_x_reg) - sx(fix_w));
                        mul_req_reg <= '{start: 1'b1, a: MUL_A_W'(mv1_reg), b: ny_s};
                        state_reg   <= ST_PY;
                    end
                end
                ST_PY: begin
                    if (mul_rsp.done) begin
                        pos_y_reg   <= sat_word(sx(pos_y_reg) - sx(fix_w));
                        mul_req_reg <= '{start: 1'b1, a: MUL_A_W'(mv2_reg), b: nx_s};
                        state_reg   <= ST_TX;
                    end
                end
                ST_TX: begin
                    if (mul_rsp.done) begin
                        tx_reg      <= sat_word(sx(in_reg.vec_x) + sx(fix_w));
                        mul_req_reg <= '{start: 1'b1, a: MUL_A_W'(mv2_reg), b: ny_s};
                        state_reg   <= ST_TY;
                    end
                end
                ST_TY: begin
                    if (mul_rsp.done) begin
                        ty_reg    <= sat_word(sx(in_reg.vec_y) + sx(fix_w));
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // hold until the output word slot is free
                    if (!out_valid_reg || m_ready) begin
                        out_reg       <= '{pos_x: pos_x_reg, pos_y: pos_y_reg,
                                           target_x: tx_reg, target_y: ty_reg,
                                           status: status_reg};
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

[hdl/vcb_checker.sv]
// port-level checks for verlet_circle_body_step, bound to the top level
// depends on vcb_pkg and verlet_circle_body_step
`timescale 1ns / 1ps

module vcb_checker import vcb_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input in_word_t              s_data,
    input logic                  m_valid,
    input logic                  m_ready,
    input out_word_t             m_data,
    input logic                  cfg_wr_en,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_wr_data
);

    // reset leaves no word pending and the input open
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("output not empty or input closed after reset");

    // one command in flight: input closes right after a word is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input open while a command is in flight");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result word changed or dropped");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("stalled input word changed or dropped");

endmodule

bind verlet_circle_body_step vcb_checker u_vcb_checker (.*);
